[sv/depth_grid_triangulator_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the depth grid triangulator
// Concurrent checks clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef DEPTH_GRID_TRIANGULATOR_DEFINES_SVH
`define DEPTH_GRID_TRIANGULATOR_DEFINES_SVH

// Condition must hold at every clock edge
`define DGT_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent
`define DGT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define DGT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/dgt_pkg.sv]
// ----------------------------------------------------------------------------
// dgt_pkg
// Shared types and constants of the depth grid triangulator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dgt_pkg;

  // Image geometry limits
  localparam int unsigned MAX_WIDTH  = 320;
  localparam int unsigned MAX_HEIGHT = 240;

  // Field widths
  localparam int unsigned COL_W   = 9;
  localparam int unsigned ROW_W   = 8;
  localparam int unsigned DEPTH_W = 16;
  localparam int unsigned IDX_W   = 17;
  localparam int unsigned FACE_W  = 18;

  // Results one pixel can cause: pixel record and at most two triangles
  localparam int unsigned MAX_RESULTS = 3;

  // Register reset values
  localparam int unsigned DEPTH_FULL_SCALE = 65535;
  localparam logic [COL_W-1:0]   WIDTH_RST  = COL_W'(MAX_WIDTH);
  localparam logic [ROW_W-1:0]   HEIGHT_RST = ROW_W'(MAX_HEIGHT);
  localparam logic [DEPTH_W-1:0] LIMIT_RST  = DEPTH_W'(DEPTH_FULL_SCALE / 10);

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_LIMIT  = 2'd2
  } cfg_reg_e;

  // Result kinds
  typedef enum logic [0:0] {
    KIND_PIXEL = 1'b0,
    KIND_TRI   = 1'b1
  } kind_e;

  // One row store entry: vertex flag and vertex number
  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] num;
  } entry_t;

  // One result item
  typedef struct packed {
    kind_e              kind;
    logic               vertex_valid;
    logic [COL_W-1:0]   col;
    logic [ROW_W-1:0]   row;
    logic [DEPTH_W-1:0] depth_out;
    logic [IDX_W-1:0]   index_a;
    logic [IDX_W-1:0]   index_b;
    logic [IDX_W-1:0]   index_c;
    logic [IDX_W-1:0]   vertex_total;
    logic [FACE_W-1:0]  face_total;
    logic               last_of_item;
    logic               frame_done;
  } rec_t;

  // Control shared by all cells of the result chain
  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctl_t;

endpackage

[sv/dgt_row_store.sv]
// ----------------------------------------------------------------------------
// dgt_row_store
// Previous-row vertex store: one write port, two registered read ports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dgt_row_store (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [dgt_pkg::COL_W-1:0] waddr_i,
  input  dgt_pkg::entry_t           wdata_i,
  input  logic                      re_i,
  input  logic [dgt_pkg::COL_W-1:0] raddr_a_i,
  input  logic [dgt_pkg::COL_W-1:0] raddr_b_i,
  output dgt_pkg::entry_t           rdata_a_o,
  output dgt_pkg::entry_t           rdata_b_o
);

  dgt_pkg::entry_t mem [dgt_pkg::MAX_WIDTH];
  dgt_pkg::entry_t rdata_a_q;
  dgt_pkg::entry_t rdata_b_q;

  // Write one entry
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read both neighbours above the new pixel; old data on a same-cycle write
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_q <= mem[raddr_a_i];
      rdata_b_q <= mem[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

[sv/dgt_cell.sv]
// ----------------------------------------------------------------------------
// dgt_cell
// One slot of the result chain: loads a result, takes its neighbour's, or holds.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dgt_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dgt_pkg::cell_ctl_t  ctl_i,
  input  logic                load_valid_i,
  input  dgt_pkg::rec_t       load_rec_i,
  input  logic                next_valid_i,
  input  dgt_pkg::rec_t       next_rec_i,
  output logic                valid_o,
  output dgt_pkg::rec_t       rec_o
);

  logic          valid_d, valid_q;
  dgt_pkg::rec_t rec_d, rec_q;

  // Load a fresh result, take the neighbour's, or hold
  always_comb begin
    valid_d = valid_q;
    rec_d   = rec_q;
    if (ctl_i.load) begin
      valid_d = load_valid_i;
      rec_d   = load_rec_i;
    end else if (ctl_i.shift) begin
      valid_d = next_valid_i;
      rec_d   = next_rec_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

  assign valid_o = valid_q;
  assign rec_o   = rec_q;

endmodule

[sv/depth_grid_triangulator.sv]
// ----------------------------------------------------------------------------
// depth_grid_triangulator
// Numbers valid depth pixels, emits a pixel record and the grid triangles of each 2x2 cell.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                  payload
//  s_axis    in   s_axis_tvalid/tready       tdata[15:0] depth
//  m_axis    out  m_axis_tvalid/tready       tdata, tuser kind, tlast last_of_item
//  cfg       in   cfg_we_i (no wait)         cfg_addr_i index, cfg_wdata_i value
//
//  A pixel has one to three results; the next pixel loads once the chain tail
//  is empty. With one result a pixel is taken every cycle unless the output
//  stalls. Results pass the registered row store read, then the chain load.
//  Reset clears position, counters and chain; the row store needs no clearing.
//  A stalled output holds the chain, then the decision stage, then the input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "depth_grid_triangulator_defines.svh"

module depth_grid_triangulator (
  input  logic          clk_i,
  input  logic          rst_ni,
  // Depth input: [15:0] depth
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [15:0]   s_axis_tdata,
  // Results: [0] vertex_valid, [9:1] col, [17:10] row, [33:18] depth_out,
  // [50:34] index_a, [67:51] index_b, [84:68] index_c, [101:85] vertex_total,
  // [119:102] face_total, [120] frame_done, [127:121] zero
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [127:0]  m_axis_tdata,
  // [0] kind
  output logic [0:0]    m_axis_tuser,
  output logic          m_axis_tlast,
  // Configuration writes
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_addr_i,
  input  logic [15:0]   cfg_wdata_i
);

  localparam int unsigned COL_W   = dgt_pkg::COL_W;
  localparam int unsigned ROW_W   = dgt_pkg::ROW_W;
  localparam int unsigned DEPTH_W = dgt_pkg::DEPTH_W;
  localparam int unsigned IDX_W   = dgt_pkg::IDX_W;
  localparam int unsigned FACE_W  = dgt_pkg::FACE_W;
  localparam int unsigned NCELL   = dgt_pkg::MAX_RESULTS;
  localparam int unsigned REC_BITS = 1 + COL_W + ROW_W + DEPTH_W + 4 * IDX_W + FACE_W + 1;
  localparam int unsigned PAD_W   = 128 - REC_BITS;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [COL_W-1:0]   width_q;
  logic [ROW_W-1:0]   height_q;
  logic [DEPTH_W-1:0] limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= dgt_pkg::WIDTH_RST;
      height_q <= dgt_pkg::HEIGHT_RST;
      limit_q  <= dgt_pkg::LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (dgt_pkg::cfg_reg_e'(cfg_addr_i))
        dgt_pkg::REG_WIDTH:  width_q  <= cfg_wdata_i[COL_W-1:0];
        dgt_pkg::REG_HEIGHT: height_q <= cfg_wdata_i[ROW_W-1:0];
        dgt_pkg::REG_LIMIT:  limit_q  <= cfg_wdata_i[DEPTH_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Front: position, vertex numbering, row store access
  // --------------------------------------------------------------------------
  logic [COL_W-1:0]   col_d, col_q;
  logic [ROW_W-1:0]   row_d, row_q;
  logic [IDX_W-1:0]   vcnt_d, vcnt_q, vcnt_inc;
  dgt_pkg::entry_t    left_q, cur;
  logic               pend_valid_d, pend_valid_q;
  logic [COL_W-1:0]   pend_addr_q;
  dgt_pkg::entry_t    pend_data_q;
  logic [COL_W-1:0]   w_eff, w_last;
  logic [ROW_W-1:0]   h_eff, h_last;
  logic [DEPTH_W-1:0] in_depth;
  logic               accept, row_end, frame_end, vv, col_nz, left_we;

  logic               mem_we;
  logic [COL_W-1:0]   mem_waddr, raddr_a;
  dgt_pkg::entry_t    mem_wdata, rd_a, rd_b;

  logic               load_ok;

  assign in_depth = s_axis_tdata[DEPTH_W-1:0];
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign col_nz   = (col_q != '0);

  // Saturate geometry into its legal range
  always_comb begin
    if (width_q < COL_W'(2)) begin
      w_eff = COL_W'(2);
    end else if (width_q > COL_W'(dgt_pkg::MAX_WIDTH)) begin
      w_eff = COL_W'(dgt_pkg::MAX_WIDTH);
    end else begin
      w_eff = width_q;
    end
    if (height_q == '0) begin
      h_eff = ROW_W'(1);
    end else if (height_q > ROW_W'(dgt_pkg::MAX_HEIGHT)) begin
      h_eff = ROW_W'(dgt_pkg::MAX_HEIGHT);
    end else begin
      h_eff = height_q;
    end
  end

  assign w_last    = w_eff - COL_W'(1);
  assign h_last    = h_eff - ROW_W'(1);
  assign row_end   = (col_q >= w_last);
  assign frame_end = row_end && (row_q >= h_last);

  // Classify the new pixel and number it
  assign vv        = (in_depth != '0) && (in_depth < limit_q);
  assign cur.valid = vv;
  assign cur.num   = vv ? vcnt_q : '0;
  assign vcnt_inc  = vv ? (vcnt_q + IDX_W'(1)) : vcnt_q;

  // Advance position and counters
  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    vcnt_d = vcnt_q;
    if (accept) begin
      vcnt_d = vcnt_inc;
      if (row_end) begin
        col_d = '0;
        if (frame_end) begin
          row_d  = '0;
          vcnt_d = '0;
        end else if (row_q >= ROW_W'(dgt_pkg::MAX_HEIGHT - 1)) begin
          row_d = '0;
        end else begin
          row_d = row_q + ROW_W'(1);
        end
      end else begin
        col_d = col_q + COL_W'(1);
      end
    end
  end

  // Write port: left neighbour moves up, else the deferred last-column entry
  assign left_we   = accept && col_nz;
  assign mem_we    = left_we || pend_valid_q;
  assign mem_waddr = left_we ? (col_q - COL_W'(1)) : pend_addr_q;
  assign mem_wdata = left_we ? left_q : pend_data_q;
  assign raddr_a   = col_nz ? (col_q - COL_W'(1)) : '0;

  always_comb begin
    pend_valid_d = pend_valid_q;
    if (accept && row_end) begin
      pend_valid_d = 1'b1;
    end else if (pend_valid_q && !left_we) begin
      pend_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q        <= '0;
      row_q        <= '0;
      vcnt_q       <= '0;
      left_q       <= '0;
      pend_valid_q <= 1'b0;
    end else begin
      col_q        <= col_d;
      row_q        <= row_d;
      vcnt_q       <= vcnt_d;
      pend_valid_q <= pend_valid_d;
      if (accept) begin
        left_q <= cur;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && row_end) begin
      pend_addr_q <= col_q;
      pend_data_q <= cur;
    end
  end

  dgt_row_store u_row_store (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (mem_waddr),
    .wdata_i   (mem_wdata),
    .re_i      (accept),
    .raddr_a_i (raddr_a),
    .raddr_b_i (col_q),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  // --------------------------------------------------------------------------
  // Decision stage: one pixel with its 2x2 cell
  // --------------------------------------------------------------------------
  logic               s1_valid_d, s1_valid_q;
  logic [DEPTH_W-1:0] s1_depth_q;
  logic [COL_W-1:0]   s1_col_q;
  logic [ROW_W-1:0]   s1_row_q;
  dgt_pkg::entry_t    s1_cur_q, s1_left_q;
  logic [IDX_W-1:0]   s1_vtot_q;
  logic               s1_fend_q, s1_tri_q;
  logic [FACE_W-1:0]  face_d, face_q;

  logic               abc, cdb, abd, cda;
  logic [1:0]         n_tri;
  logic [IDX_W-1:0]   t1_a, t1_b, t1_c;
  dgt_pkg::rec_t      load_rec   [NCELL];
  logic               load_valid [NCELL];

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (load_ok) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      face_q     <= '0;
    end else begin
      s1_valid_q <= s1_valid_d;
      face_q     <= face_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_depth_q <= in_depth;
      s1_col_q   <= col_q;
      s1_row_q   <= row_q;
      s1_cur_q   <= cur;
      s1_left_q  <= left_q;
      s1_vtot_q  <= vcnt_inc;
      s1_fend_q  <= frame_end;
      s1_tri_q   <= col_nz && (row_q != '0);
    end
  end

  // Pick the triangles of the cell: A above-left, B above, C left, D new
  always_comb begin
    abc = s1_tri_q && rd_a.valid && rd_b.valid && s1_left_q.valid;
    cdb = s1_tri_q && s1_left_q.valid && s1_cur_q.valid && rd_b.valid;
    abd = s1_tri_q && !(abc || cdb) && rd_a.valid && rd_b.valid && s1_cur_q.valid;
    cda = s1_tri_q && !(abc || cdb) && s1_left_q.valid && s1_cur_q.valid && rd_a.valid;
    if (abc && cdb) begin
      n_tri = 2'd2;
    end else if (abc || cdb || abd || cda) begin
      n_tri = 2'd1;
    end else begin
      n_tri = 2'd0;
    end
    if (abc) begin
      t1_a = rd_a.num;
      t1_b = rd_b.num;
      t1_c = s1_left_q.num;
    end else if (cdb) begin
      t1_a = s1_left_q.num;
      t1_b = s1_cur_q.num;
      t1_c = rd_b.num;
    end else if (abd) begin
      t1_a = rd_a.num;
      t1_b = rd_b.num;
      t1_c = s1_cur_q.num;
    end else begin
      t1_a = s1_left_q.num;
      t1_b = s1_cur_q.num;
      t1_c = rd_a.num;
    end
  end

  // Build the pixel record and up to two triangle records
  always_comb begin
    load_rec[0].kind         = dgt_pkg::KIND_PIXEL;
    load_rec[0].vertex_valid = s1_cur_q.valid;
    load_rec[0].col          = s1_col_q;
    load_rec[0].row          = s1_row_q;
    load_rec[0].depth_out    = s1_depth_q;
    load_rec[0].index_a      = s1_cur_q.num;
    load_rec[0].index_b      = '0;
    load_rec[0].index_c      = '0;
    load_rec[0].vertex_total = s1_vtot_q;
    load_rec[0].face_total   = face_q;
    load_rec[0].last_of_item = (n_tri == 2'd0);
    load_rec[0].frame_done   = s1_fend_q;

    load_rec[1].kind         = dgt_pkg::KIND_TRI;
    load_rec[1].vertex_valid = 1'b0;
    load_rec[1].col          = s1_col_q;
    load_rec[1].row          = s1_row_q;
    load_rec[1].depth_out    = '0;
    load_rec[1].index_a      = t1_a;
    load_rec[1].index_b      = t1_b;
    load_rec[1].index_c      = t1_c;
    load_rec[1].vertex_total = s1_vtot_q;
    load_rec[1].face_total   = face_q + FACE_W'(1);
    load_rec[1].last_of_item = (n_tri == 2'd1);
    load_rec[1].frame_done   = s1_fend_q;

    // Second triangle only ever follows ABC, so it is CDB
    load_rec[2].kind         = dgt_pkg::KIND_TRI;
    load_rec[2].vertex_valid = 1'b0;
    load_rec[2].col          = s1_col_q;
    load_rec[2].row          = s1_row_q;
    load_rec[2].depth_out    = '0;
    load_rec[2].index_a      = s1_left_q.num;
    load_rec[2].index_b      = s1_cur_q.num;
    load_rec[2].index_c      = rd_b.num;
    load_rec[2].vertex_total = s1_vtot_q;
    load_rec[2].face_total   = face_q + FACE_W'(2);
    load_rec[2].last_of_item = 1'b1;
    load_rec[2].frame_done   = s1_fend_q;

    load_valid[0] = 1'b1;
    load_valid[1] = (n_tri != 2'd0);
    load_valid[2] = (n_tri == 2'd2);
  end

  // Count faces as the pixel leaves; restart after the final pixel
  always_comb begin
    face_d = face_q;
    if (load_ok) begin
      face_d = s1_fend_q ? '0 : (face_q + FACE_W'(n_tri));
    end
  end

  // --------------------------------------------------------------------------
  // Result chain: cell 0 drives the output
  // --------------------------------------------------------------------------
  dgt_pkg::cell_ctl_t cell_ctl;
  logic               cell_valid [NCELL];
  dgt_pkg::rec_t      cell_rec   [NCELL];
  logic               nxt_valid  [NCELL];
  dgt_pkg::rec_t      nxt_rec    [NCELL];
  logic               chain_adv, tail_empty;

  assign chain_adv = !cell_valid[0] || m_axis_tready;

  always_comb begin
    tail_empty = 1'b1;
    for (int i = 1; i < NCELL; i++) begin
      if (cell_valid[i]) begin
        tail_empty = 1'b0;
      end
    end
  end

  assign load_ok        = s1_valid_q && tail_empty && chain_adv;
  assign cell_ctl.load  = load_ok;
  assign cell_ctl.shift = chain_adv;
  assign s_axis_tready  = !s1_valid_q || load_ok;

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    if (i < NCELL - 1) begin : g_link
      assign nxt_valid[i] = cell_valid[i+1];
      assign nxt_rec[i]   = cell_rec[i+1];
    end else begin : g_tail
      assign nxt_valid[i] = 1'b0;
      assign nxt_rec[i]   = '0;
    end

    dgt_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (cell_ctl),
      .load_valid_i (load_valid[i]),
      .load_rec_i   (load_rec[i]),
      .next_valid_i (nxt_valid[i]),
      .next_rec_i   (nxt_rec[i]),
      .valid_o      (cell_valid[i]),
      .rec_o        (cell_rec[i])
    );
  end

  // Drive the output item
  assign m_axis_tvalid = cell_valid[0];
  assign m_axis_tuser  = cell_rec[0].kind;
  assign m_axis_tlast  = cell_rec[0].last_of_item;
  assign m_axis_tdata  = {PAD_W'(0),
                          cell_rec[0].frame_done,
                          cell_rec[0].face_total,
                          cell_rec[0].vertex_total,
                          cell_rec[0].index_c,
                          cell_rec[0].index_b,
                          cell_rec[0].index_a,
                          cell_rec[0].depth_out,
                          cell_rec[0].row,
                          cell_rec[0].col,
                          cell_rec[0].vertex_valid};

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `DGT_ASSERT_NOW(a_write_port_free, pend_valid_q, !left_we, "deferred entry meets a left write")
  `DGT_ASSERT_ALWAYS(a_chain_packed, (!cell_valid[2] || cell_valid[1]) && (!cell_valid[1] || cell_valid[0]), "gap in result chain")
  `DGT_ASSERT_NEXT(a_frame_restart, accept && frame_end, col_q == '0 && row_q == '0 && vcnt_q == '0, "position not cleared at frame end")
  `DGT_ASSERT_NEXT(a_stage_hold, s1_valid_q && !load_ok, s1_valid_q && $stable(s1_cur_q) && $stable(rd_b), "stalled pixel lost")

endmodule
